FILE: hw/rtl/sbs_pkg.sv
package sbs_pkg;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_OFFLINE    = 3'd0,
    PH_INIT       = 3'd1,
    PH_START_INIT = 3'd2,
    PH_SPRK_DOWN  = 3'd3,
    PH_DATA_OUT   = 3'd4
  } phase_t;

  // Request action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIndexWidth = 3;
  localparam logic [CfgIndexWidth-1:0] CFG_START_ADDRESS     = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_BYTE_COUNT        = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_DOWN_DELAY        = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_UP_DELAY          = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_DATA_FROM_ADDRESS = 3'd4;

  localparam int unsigned CfgDataWidth = 16;

  // Configuration reset values
  localparam logic [15:0] START_ADDRESS_RESET = 16'h0041;
  localparam logic [15:0] BYTE_COUNT_RESET    = 16'd0;
  localparam logic [15:0] DOWN_DELAY_RESET    = 16'd500;
  localparam logic [15:0] UP_DELAY_RESET      = 16'd1000;

  typedef struct packed {
    logic [15:0] start_address;
    logic [15:0] byte_count;
    logic [15:0] down_delay;
    logic [15:0] up_delay;
    logic        data_from_address;
  } cfg_t;

  typedef struct packed {
    logic        start_stop;
    logic        sprocket;
    logic [7:0]  data_out;
    logic [15:0] fetch_address;
    logic        busy_res;
  } result_t;

endpackage

FILE: hw/rtl/sbs_seq.sv
module sbs_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [1:0]        action,
  input  logic [7:0]        mem_byte,
  input  sbs_pkg::cfg_t     cfg,
  output sbs_pkg::result_t  res_next
);

  sbs_pkg::phase_t phase, phase_next;
  logic [15:0] delay_left, delay_left_next;
  logic [15:0] cur_address, cur_address_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic        start_stop_level, start_stop_level_next;
  logic        sprocket_level, sprocket_level_next;
  logic [7:0]  data_level, data_level_next;
  logic [15:0] delay_dec;

  // Count the delay down, saturating at zero
  assign delay_dec = (delay_left != 16'd0) ? delay_left - 16'd1 : 16'd0;

  // Work out the state after one request
  always_comb begin
    phase_next            = phase;
    delay_left_next       = delay_left;
    cur_address_next      = cur_address;
    bytes_left_next       = bytes_left;
    start_stop_level_next = start_stop_level;
    sprocket_level_next   = sprocket_level;
    data_level_next       = data_level;
    case (action)
      sbs_pkg::ACT_TICK: begin
        if (phase != sbs_pkg::PH_OFFLINE) begin
          delay_left_next = delay_dec;
          case (phase)
            sbs_pkg::PH_INIT: begin
              start_stop_level_next = 1'b0;
              sprocket_level_next   = 1'b1;
              phase_next            = sbs_pkg::PH_START_INIT;
            end
            sbs_pkg::PH_START_INIT: begin
              if (delay_dec == 16'd0) begin
                start_stop_level_next = 1'b1;
                delay_left_next       = cfg.down_delay;
                phase_next            = sbs_pkg::PH_SPRK_DOWN;
              end
            end
            sbs_pkg::PH_SPRK_DOWN: begin
              if (delay_dec == 16'd0) begin
                if (bytes_left == 16'd0) begin
                  phase_next = sbs_pkg::PH_OFFLINE;
                end else begin
                  sprocket_level_next = 1'b0;
                  delay_left_next     = cfg.down_delay;
                  phase_next          = sbs_pkg::PH_DATA_OUT;
                end
              end
            end
            sbs_pkg::PH_DATA_OUT: begin
              if (delay_dec == 16'd0) begin
                if (bytes_left == 16'd1) begin
                  start_stop_level_next = 1'b0;
                end
                data_level_next     = cfg.data_from_address ? cur_address[7:0] : mem_byte;
                cur_address_next    = cur_address + 16'd1;
                bytes_left_next     = bytes_left - 16'd1;
                sprocket_level_next = 1'b1;
                delay_left_next     = cfg.up_delay;
                phase_next          = sbs_pkg::PH_SPRK_DOWN;
              end
            end
            default: begin
              phase_next = sbs_pkg::PH_OFFLINE;
            end
          endcase
        end
      end
      sbs_pkg::ACT_START: begin
        cur_address_next = cfg.start_address;
        bytes_left_next  = cfg.byte_count;
        phase_next       = sbs_pkg::PH_INIT;
      end
      sbs_pkg::ACT_STOP: begin
        phase_next = sbs_pkg::PH_OFFLINE;
      end
      default: begin
        // unused code: hold everything
      end
    endcase
  end

  // Present the updated line levels, fetch address and busy flag as the result
  always_comb begin
    res_next.start_stop    = start_stop_level_next;
    res_next.sprocket      = sprocket_level_next;
    res_next.data_out      = data_level_next;
    res_next.fetch_address = cur_address_next;
    res_next.busy_res      = (phase_next != sbs_pkg::PH_OFFLINE);
  end

  // Hold sequencer state, advance on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= sbs_pkg::PH_OFFLINE;
      delay_left       <= 16'd0;
      cur_address      <= 16'd0;
      bytes_left       <= 16'd0;
      start_stop_level <= 1'b0;
      sprocket_level   <= 1'b1;
      data_level       <= 8'd0;
    end else if (step) begin
      phase            <= phase_next;
      delay_left       <= delay_left_next;
      cur_address      <= cur_address_next;
      bytes_left       <= bytes_left_next;
      start_stop_level <= start_stop_level_next;
      sprocket_level   <= sprocket_level_next;
      data_level       <= data_level_next;
    end
  end

endmodule

FILE: hw/rtl/sbs_out_buf.sv
module sbs_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sbs_pkg::result_t  res_in,
  output logic              free,
  output logic              valid,
  input  logic              ready,
  output sbs_pkg::result_t  res_out
);

  // Take a new result whenever the held one is gone or leaving
  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (free && load) begin
      res_out <= res_in;
    end
  end

endmodule

FILE: hw/rtl/strobed_byte_sender.sv
// A result appears in the cycle after its request is accepted. The block takes
// one request per cycle while its result register is empty or being read out;
// a held result with out_ready low stalls further requests.
// Reset (synchronous, active high) returns the sequencer to offline with the
// sprocket high and restores the configuration registers to their defaults.
module strobed_byte_sender (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  mem_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        start_stop,
  output logic        sprocket,
  output logic [7:0]  data_out,
  output logic [15:0] fetch_address,
  output logic        busy_res
);

  sbs_pkg::cfg_t    cfg;
  sbs_pkg::result_t res_next;
  sbs_pkg::result_t res_q;
  logic             step;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_address     <= sbs_pkg::START_ADDRESS_RESET;
      cfg.byte_count        <= sbs_pkg::BYTE_COUNT_RESET;
      cfg.down_delay        <= sbs_pkg::DOWN_DELAY_RESET;
      cfg.up_delay          <= sbs_pkg::UP_DELAY_RESET;
      cfg.data_from_address <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sbs_pkg::CFG_START_ADDRESS:     cfg.start_address     <= cfg_data;
        sbs_pkg::CFG_BYTE_COUNT:        cfg.byte_count        <= cfg_data;
        sbs_pkg::CFG_DOWN_DELAY:        cfg.down_delay        <= cfg_data;
        sbs_pkg::CFG_UP_DELAY:          cfg.up_delay          <= cfg_data;
        sbs_pkg::CFG_DATA_FROM_ADDRESS: cfg.data_from_address <= cfg_data[0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  assign step = in_valid && in_ready;

  sbs_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .action   (action),
    .mem_byte (mem_byte),
    .cfg      (cfg),
    .res_next (res_next)
  );

  sbs_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .load    (in_valid),
    .res_in  (res_next),
    .free    (in_ready),
    .valid   (out_valid),
    .ready   (out_ready),
    .res_out (res_q)
  );

  assign start_stop    = res_q.start_stop;
  assign sprocket      = res_q.sprocket;
  assign data_out      = res_q.data_out;
  assign fetch_address = res_q.fetch_address;
  assign busy_res      = res_q.busy_res;

endmodule

FILE: hw/rtl/sbs_checker.sv
module sbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        start_stop,
  input logic        sprocket,
  input logic [7:0]  data_out,
  input logic [15:0] fetch_address,
  input logic        busy_res
);

  // No result is shown straight after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // An empty result register never blocks a request
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("request refused with empty result register");

  // Every accepted request yields a result in the next cycle
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> out_valid)
    else $error("accepted request gave no result");

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(start_stop) && $stable(sprocket)
      && $stable(data_out) && $stable(fetch_address) && $stable(busy_res)))
    else $error("stalled result changed");

endmodule

bind strobed_byte_sender sbs_checker u_sbs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .start_stop    (start_stop),
  .sprocket      (sprocket),
  .data_out      (data_out),
  .fetch_address (fetch_address),
  .busy_res      (busy_res)
);

FILE: tb/tb_strobed_byte_sender.sv
`timescale 1ns / 100ps

module tb_strobed_byte_sender;

  // Action code that the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int RAND_PHASES = 10;
  localparam int STALL_LIMIT = 4000;
  // Receiver windows, in cycles after reset
  localparam int HOLD_FROM   = 700;
  localparam int HOLD_TO     = 900;
  localparam int CALM_FROM   = 1200;
  localparam int CALM_TO     = 1700;

  typedef struct {
    bit                 is_cfg;
    logic [2:0]         idx;
    logic [15:0]        value;
    logic [1:0]         act;
    logic [7:0]         mem;
    bit                 known;
    sbs_pkg::result_t   want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = sbs_pkg::CFG_START_ADDRESS;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = sbs_pkg::ACT_TICK;
  logic [7:0]  mem_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        start_stop;
  logic        sprocket;
  logic [7:0]  data_out;
  logic [15:0] fetch_address;
  logic        busy_res;

  // Typed-in expectation travelling with the request
  bit                 exp_known = 1'b0;
  sbs_pkg::result_t   exp_levels = '0;

  // Predictor copy of the configuration
  logic [15:0] cfg_addr;
  logic [15:0] cfg_count;
  logic [15:0] cfg_down;
  logic [15:0] cfg_up;
  logic        cfg_dfa;

  // Predictor copy of the sequencer
  sbs_pkg::phase_t seq_phase;
  logic [15:0] dly_left;
  logic [15:0] addr_cnt;
  logic [15:0] bytes_rem;
  logic        ss_lvl;
  logic        spr_lvl;
  logic [7:0]  data_lvl;

  sbs_pkg::result_t pending_levels[$];
  int          mismatches = 0;
  bit          steady = 1'b0;

  strobed_byte_sender DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .mem_byte     (mem_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .start_stop   (start_stop),
    .sprocket     (sprocket),
    .data_out     (data_out),
    .fetch_address(fetch_address),
    .busy_res     (busy_res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the sequencer by one request and return the line levels after it
  function automatic sbs_pkg::result_t predict_levels(logic [1:0] act, logic [7:0] mem);
    sbs_pkg::result_t r;
    if (act == sbs_pkg::ACT_TICK) begin
      if (seq_phase != sbs_pkg::PH_OFFLINE) begin
        if (dly_left != 16'd0) dly_left = dly_left - 16'd1;
        case (seq_phase)
          sbs_pkg::PH_INIT: begin
            ss_lvl    = 1'b0;
            spr_lvl   = 1'b1;
            seq_phase = sbs_pkg::PH_START_INIT;
          end
          sbs_pkg::PH_START_INIT: begin
            if (dly_left == 16'd0) begin
              ss_lvl    = 1'b1;
              dly_left  = cfg_down;
              seq_phase = sbs_pkg::PH_SPRK_DOWN;
            end
          end
          sbs_pkg::PH_SPRK_DOWN: begin
            if (dly_left == 16'd0) begin
              if (bytes_rem == 16'd0) begin
                seq_phase = sbs_pkg::PH_OFFLINE;
              end else begin
                spr_lvl   = 1'b0;
                dly_left  = cfg_down;
                seq_phase = sbs_pkg::PH_DATA_OUT;
              end
            end
          end
          sbs_pkg::PH_DATA_OUT: begin
            if (dly_left == 16'd0) begin
              // drop start/stop on the last byte
              if (bytes_rem == 16'd1) ss_lvl = 1'b0;
              data_lvl  = cfg_dfa ? addr_cnt[7:0] : mem;
              addr_cnt  = addr_cnt + 16'd1;
              bytes_rem = bytes_rem - 16'd1;
              spr_lvl   = 1'b1;
              dly_left  = cfg_up;
              seq_phase = sbs_pkg::PH_SPRK_DOWN;
            end
          end
          default: seq_phase = sbs_pkg::PH_OFFLINE;
        endcase
      end
    end else if (act == sbs_pkg::ACT_START) begin
      addr_cnt  = cfg_addr;
      bytes_rem = cfg_count;
      seq_phase = sbs_pkg::PH_INIT;
    end else if (act == sbs_pkg::ACT_STOP) begin
      seq_phase = sbs_pkg::PH_OFFLINE;
    end
    r.start_stop    = ss_lvl;
    r.sprocket      = spr_lvl;
    r.data_out      = data_lvl;
    r.fetch_address = addr_cnt;
    r.busy_res      = (seq_phase != sbs_pkg::PH_OFFLINE);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic row_t req_row(logic [1:0] act, logic [7:0] mem);
    row_t r;
    r = '{is_cfg: 1'b0, idx: sbs_pkg::CFG_START_ADDRESS, value: '0, act: act, mem: mem,
          known: 1'b0, want: '0};
    return r;
  endfunction

  function automatic row_t known_row(logic [1:0] act, logic [7:0] mem, logic ss, logic spr,
                                     logic [7:0] data, logic [15:0] addr, logic busy);
    row_t r;
    r = req_row(act, mem);
    r.known = 1'b1;
    r.want  = '{start_stop: ss, sprocket: spr, data_out: data, fetch_address: addr,
                busy_res: busy};
    return r;
  endfunction

  function automatic row_t cfg_row(logic [2:0] idx, logic [15:0] value);
    row_t r;
    r = req_row(sbs_pkg::ACT_TICK, 8'h00);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = value;
    return r;
  endfunction

  // Offer one request, idling at random first unless steady, and hold it until accepted
  task automatic send_request(logic [1:0] act, logic [7:0] mem, bit known,
                              sbs_pkg::result_t want);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    mem_byte   <= mem;
    exp_known  <= known;
    exp_levels <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drain all results, let the pipeline settle, then write one register
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_all(logic [15:0] addr, logic [15:0] count, logic [15:0] down,
                             logic [15:0] up, logic dfa);
    write_reg(sbs_pkg::CFG_START_ADDRESS, addr);
    write_reg(sbs_pkg::CFG_BYTE_COUNT, count);
    write_reg(sbs_pkg::CFG_DOWN_DELAY, down);
    write_reg(sbs_pkg::CFG_UP_DELAY, up);
    write_reg(sbs_pkg::CFG_DATA_FROM_ADDRESS, {15'd0, dfa});
  endtask

  // Track accepted requests, results and register writes
  always @(posedge clk) begin : monitor
    sbs_pkg::result_t want;
    sbs_pkg::result_t lvl;
    if (rst) begin
      cfg_addr  = sbs_pkg::START_ADDRESS_RESET;
      cfg_count = sbs_pkg::BYTE_COUNT_RESET;
      cfg_down  = sbs_pkg::DOWN_DELAY_RESET;
      cfg_up    = sbs_pkg::UP_DELAY_RESET;
      cfg_dfa   = 1'b0;
      seq_phase = sbs_pkg::PH_OFFLINE;
      dly_left  = '0;
      addr_cnt  = '0;
      bytes_rem = '0;
      ss_lvl    = 1'b0;
      spr_lvl   = 1'b1;
      data_lvl  = '0;
      pending_levels.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_levels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %0h", $time,
                   {start_stop, sprocket, data_out, fetch_address, busy_res});
        end else begin
          want = pending_levels.pop_front();
          check_field("start_stop", 16'(want.start_stop), 16'(start_stop));
          check_field("sprocket", 16'(want.sprocket), 16'(sprocket));
          check_field("data_out", 16'(want.data_out), 16'(data_out));
          check_field("fetch_address", want.fetch_address, fetch_address);
          check_field("busy_res", 16'(want.busy_res), 16'(busy_res));
        end
      end
      if (in_valid && in_ready) begin
        lvl = predict_levels(action, mem_byte);
        pending_levels.push_back(exp_known ? exp_levels : lvl);
      end
      if (cfg_we) begin
        case (cfg_index)
          sbs_pkg::CFG_START_ADDRESS:     cfg_addr  = cfg_data;
          sbs_pkg::CFG_BYTE_COUNT:        cfg_count = cfg_data;
          sbs_pkg::CFG_DOWN_DELAY:        cfg_down  = cfg_data;
          sbs_pkg::CFG_UP_DELAY:          cfg_up    = cfg_data;
          sbs_pkg::CFG_DATA_FROM_ADDRESS: cfg_dfa   = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Receiver: random stalls, one long hold-off, one stretch always ready
  always @(posedge clk) begin : receiver
    int rx_cycle;
    if (rst) begin
      rx_cycle = 0;
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_TO) out_ready <= 1'b0;
      else if (rx_cycle >= CALM_FROM && rx_cycle < CALM_TO) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 32);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    int stall_cycles;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    row_t        rows[$];
    int          sent;
    int          quota;
    int          pick;
    int          run;
    logic [15:0] r_addr;
    logic [15:0] r_count;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: tick and unused code while offline, then start and stop
    rows.push_back(known_row(sbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b1, 8'h00, 16'h0000, 1'b0));
    rows.push_back(known_row(ACT_UNUSED, 8'hFF, 1'b0, 1'b1, 8'h00, 16'h0000, 1'b0));
    rows.push_back(known_row(sbs_pkg::ACT_START, 8'h00, 1'b0, 1'b1, 8'h00, 16'h0041, 1'b1));
    rows.push_back(known_row(sbs_pkg::ACT_STOP, 8'h00, 1'b0, 1'b1, 8'h00, 16'h0041, 1'b0));
    // Two bytes with zero delays across the address wrap
    rows.push_back(cfg_row(sbs_pkg::CFG_START_ADDRESS, 16'hFFFF));
    rows.push_back(cfg_row(sbs_pkg::CFG_BYTE_COUNT, 16'd2));
    rows.push_back(cfg_row(sbs_pkg::CFG_DOWN_DELAY, 16'd0));
    rows.push_back(cfg_row(sbs_pkg::CFG_UP_DELAY, 16'd0));
    rows.push_back(req_row(sbs_pkg::ACT_START, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'hFF));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'hA5));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'hFF));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h5A));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h3C));
    // Zero byte count leaves start/stop high
    rows.push_back(cfg_row(sbs_pkg::CFG_BYTE_COUNT, 16'd0));
    rows.push_back(req_row(sbs_pkg::ACT_START, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h11));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h22));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h33));
    // Address byte as data, stop in the up delay, restart with the delay pending
    rows.push_back(cfg_row(sbs_pkg::CFG_DATA_FROM_ADDRESS, 16'd1));
    rows.push_back(cfg_row(sbs_pkg::CFG_BYTE_COUNT, 16'd1));
    rows.push_back(cfg_row(sbs_pkg::CFG_START_ADDRESS, 16'h12FF));
    rows.push_back(cfg_row(sbs_pkg::CFG_UP_DELAY, 16'd3));
    rows.push_back(req_row(sbs_pkg::ACT_START, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_STOP, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_START, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_START, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h00));
    rows.push_back(req_row(sbs_pkg::ACT_TICK, 8'h00));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].value);
      else send_request(rows[i].act, rows[i].mem, rows[i].known, rows[i].want);
    end

    // Random phases: first all zero, last all at maximum, the rest random with small counts and delays
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        program_all(16'h0000, 16'd0, 16'd0, 16'd0, 1'b0);
        quota = 90;
      end else if (ph == RAND_PHASES - 1) begin
        program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        quota = 60;
      end else begin
        r_addr  = ($urandom_range(3) == 0) ? 16'hFFFF - 16'($urandom_range(4))
                                           : 16'($urandom_range(16'hFFFF));
        r_count = ($urandom_range(7) == 0) ? 16'($urandom_range(40))
                                           : 16'($urandom_range(6));
        program_all(r_addr, r_count, 16'($urandom_range(4)), 16'($urandom_range(4)),
                    1'($urandom_range(1)));
        quota = 125;
      end
      steady = (ph == 3);
      sent = 0;
      // Mostly a start followed by a run of ticks, with stray commands mixed in
      while (sent < quota) begin
        send_request(sbs_pkg::ACT_START, 8'($urandom_range(255)), 1'b0, '0);
        sent++;
        run = $urandom_range(70, 5);
        while (run > 0 && sent < quota) begin
          run--;
          pick = $urandom_range(99);
          if (pick < 3) begin
            send_request(sbs_pkg::ACT_STOP, 8'($urandom_range(255)), 1'b0, '0);
            sent++;
          end else if (pick < 5) begin
            send_request(ACT_UNUSED, 8'($urandom_range(255)), 1'b0, '0);
          end else if (pick < 8) begin
            send_request(sbs_pkg::ACT_START, 8'($urandom_range(255)), 1'b0, '0);
            sent++;
          end else begin
            send_request(sbs_pkg::ACT_TICK, 8'($urandom_range(255)), 1'b0, '0);
            sent++;
          end
        end
      end
    end
    steady = 1'b0;

    // Drain and let the last result settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
